FILE: sv/mnpr_pkg.sv
// ----------------------------------------------------------------------------
// mnpr_pkg
// shared types and constants for the midi note parser and remapper
// ----------------------------------------------------------------------------
package mnpr_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] NOTE_MASK   = 8'h7F;
  localparam logic [7:0] STATUS_LOW  = 8'h80;
  localparam logic [7:0] STATUS_END  = 8'hF0;
  localparam logic [7:0] NOTE_OFF    = 8'h80;
  localparam logic [7:0] NOTE_ON     = 8'h90;
  localparam logic [7:0] NOTE_ON_END = 8'hA0;

  // remap modes
  localparam logic [1:0] MODE_PASS    = 2'd0;
  localparam logic [1:0] MODE_FLIP    = 2'd1;
  localparam logic [1:0] MODE_MIRROR  = 2'd2;
  localparam logic [1:0] MODE_RESET   = MODE_FLIP;

  // byte position within an outgoing message
  localparam logic [1:0] POS_STATUS   = 2'd0;
  localparam logic [1:0] POS_NOTE     = 2'd1;
  localparam logic [1:0] POS_VELOCITY = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_VEL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] note;
    logic [7:0] velocity;
  } msg_t;

endpackage

FILE: sv/mnpr_front.sv
// ----------------------------------------------------------------------------
// mnpr_front
// byte parser: tracks status, note and velocity and remaps the note
// ----------------------------------------------------------------------------
module mnpr_front
  import mnpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] remap_mode,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       push_valid,
  input  logic       push_ready,
  output msg_t       push_msg
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] note_r, note_nxt;
  logic       accept;

  function automatic logic [7:0] remap_note(input logic [7:0] note, input logic [1:0] mode);
    logic [7:0] n;
    logic [7:0] res;
    n   = note & NOTE_MASK;
    res = note;
    unique case (mode)
      MODE_FLIP: begin
        res = (n < 8'd3) ? 8'd0 : 8'd130 - n;
      end
      MODE_MIRROR: begin
        if (n <= 8'd62) res = n;
        else if (n <= 8'd123) res = 8'd124 - n;
        else res = 8'd0;
      end
      default: res = note;
    endcase
    return res;
  endfunction

  assign accept = in_valid && in_ready;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        PH_NOTE: begin
          phase_nxt = (status_r >= NOTE_OFF && status_r < NOTE_ON_END) ? PH_VEL : PH_IDLE;
        end
        PH_VEL: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = (in_byte >= STATUS_LOW && in_byte < STATUS_END) ? PH_NOTE : PH_IDLE;
        end
      endcase
    end
  end

  // outputs and held bytes
  always_comb begin
    status_nxt = status_r;
    note_nxt   = note_r;
    in_ready   = 1'b1;
    push_valid = 1'b0;
    push_msg   = '{status: status_r, note: remap_note(note_r, remap_mode), velocity: in_byte};
    unique case (phase_r)
      PH_NOTE: begin
        if (accept && status_r >= NOTE_OFF && status_r < NOTE_ON_END) note_nxt = in_byte;
      end
      PH_VEL: begin
        in_ready   = push_ready;
        push_valid = in_valid;
      end
      default: begin
        if (accept && in_byte >= STATUS_LOW && in_byte < STATUS_END) status_nxt = in_byte;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      status_r <= '0;
      note_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      note_r   <= note_nxt;
    end
  end

endmodule

FILE: sv/mnpr_queue.sv
// ----------------------------------------------------------------------------
// mnpr_queue
// small fifo of complete messages between parser and serialiser
// ----------------------------------------------------------------------------
module mnpr_queue
  import mnpr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  msg_t push_msg,
  output logic pop_valid,
  input  logic pop_ready,
  output msg_t pop_msg
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  msg_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_msg    = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_msg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: sv/mnpr_back.sv
// ----------------------------------------------------------------------------
// mnpr_back
// serialiser: sends each message as status, note, velocity
// ----------------------------------------------------------------------------
module mnpr_back
  import mnpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  msg_t       pop_msg,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_message
);

  logic       busy_r, busy_nxt;
  logic [1:0] pos_r, pos_nxt;
  msg_t       msg_r, msg_nxt;
  logic       out_acc;
  logic       take;

  assign out_acc   = busy_r && out_ready;
  assign take      = !busy_r || (out_acc && pos_r == POS_VELOCITY);
  assign pop_ready = take;

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    msg_nxt  = msg_r;
    if (take) begin
      busy_nxt = pop_valid;
      pos_nxt  = POS_STATUS;
      msg_nxt  = pop_msg;
    end else if (out_acc) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_comb begin
    out_valid           = busy_r;
    out_last_of_message = (pos_r == POS_VELOCITY);
    unique case (pos_r)
      POS_STATUS:   out_byte = msg_r.status;
      POS_NOTE:     out_byte = msg_r.note;
      default:      out_byte = msg_r.velocity;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_STATUS;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    msg_r <= msg_nxt;
  end

endmodule

FILE: sv/midi_note_parser_remapper.sv
// ----------------------------------------------------------------------------
// midi_note_parser_remapper
// midi note-on/off parser with selectable note remapping
// ----------------------------------------------------------------------------
// usage
//   in_*  : one received midi byte per transaction; in_ready is high except when
//           a velocity byte is awaited while the message queue is full
//   out_* : each complete note message leaves as three transactions: status,
//           remapped note, velocity (out_last_of_message set on the velocity)
//   cfg_* : writes remap_mode (0 pass, 1 flipped, 2 mirrored); cfg_ready is
//           always high, write only while the block is idle
// path: the velocity byte is written into the queue, then the serialiser
//   loads the message into its register and offers the status byte; note and
//   velocity follow while out_ready holds
// throughput: one input byte per cycle while in_ready holds, one output byte
//   per cycle while out_ready holds; three bytes per message set the output
//   side, and the queue (QUEUE_DEPTH messages) decouples parsing from sending
// reset: parser back to waiting for status, queue and serialiser empty,
//   remap_mode to flipped
// a stalled receiver fills the queue, then in_ready drops on the next velocity
// ----------------------------------------------------------------------------
module midi_note_parser_remapper
  import mnpr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_remap_mode,
  // byte input
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  // byte output
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last_of_message
);

  logic [1:0] remap_mode_r, remap_mode_nxt;

  // front to queue
  logic push_valid, push_ready;
  msg_t push_msg;
  // queue to back
  logic pop_valid, pop_ready;
  msg_t pop_msg;

  // remap register, sampled by the parser when the message completes
  assign cfg_ready      = 1'b1;
  assign remap_mode_nxt = (cfg_valid && cfg_ready) ? cfg_remap_mode : remap_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      remap_mode_r <= MODE_RESET;
    end else begin
      remap_mode_r <= remap_mode_nxt;
    end
  end

  // parser front end
  mnpr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .remap_mode (remap_mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_byte    (in_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_msg   (push_msg)
  );

  // message queue
  mnpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_msg   (push_msg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_msg    (pop_msg)
  );

  // serialiser back end
  mnpr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pop_valid           (pop_valid),
    .pop_ready           (pop_ready),
    .pop_msg             (pop_msg),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_last_of_message (out_last_of_message)
  );

endmodule

FILE: dv/tb_midi_note_parser_remapper.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_note_parser_remapper
// self-checking bench for the midi note parser and remapper
// ----------------------------------------------------------------------------
// a queue of midi bytes feeds a clocked driver; a clocked monitor takes the
// outgoing bytes and checks them against a software parser kept in step with
// every accepted input transaction. the run covers a short directed stream,
// then random note traffic under every remap mode, with random gaps on both
// sides, a gap-free stretch and one long receiver hold-off that fills the
// block's message queue and pushes back on the input
// ----------------------------------------------------------------------------
module tb_midi_note_parser_remapper;
  import mnpr_pkg::*;

  localparam int          HALF_PERIOD   = 6;
  localparam int          RESET_CYCLES  = 4;
  localparam int          SETTLE_CYCLES = 10;      // settle time after the block drains
  localparam int          HOLD_CYCLES   = 120;     // long receiver hold-off
  localparam int          CYCLE_LIMIT   = 200000;
  localparam logic [1:0]  MODE_UNUSED   = 2'd3;    // undefined encoding, behaves as pass

  // notes around the remap break points, low 7 bits
  localparam logic [7:0] NOTE_BOUNDS [8] = '{8'd0, 8'd2, 8'd3, 8'd62,
                                             8'd63, 8'd123, 8'd124, 8'd127};

  typedef struct {
    logic [7:0] data;
    logic       last;
  } midi_tx_t;

  // clock, reset and block ports
  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_remap_mode = 2'd0;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte        = 8'h00;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [7:0] out_byte;
  logic       out_last_of_message;

  // stimulus and expectation stores
  logic [7:0] pending_bytes [$];
  midi_tx_t   expected_tx [$];

  // shadow copy of the parser state and the remap register
  phase_t     parse_state   = PH_IDLE;
  logic [7:0] held_status   = 8'h00;
  logic [7:0] held_note     = 8'h00;
  logic [1:0] remap_setting = MODE_RESET;

  // pacing controls, set by the sequence below
  bit sender_idles   = 1'b0;
  bit receiver_idles = 1'b0;
  bit hold_go        = 1'b0;
  bit receiver_hold  = 1'b0;
  int tx_wait        = 0;
  int rx_wait        = 0;

  // bookkeeping
  int unsigned error_count   = 0;
  int unsigned bytes_taken   = 0;
  int unsigned messages_seen = 0;
  int unsigned results_seen  = 0;
  int unsigned input_stalls  = 0;
  int unsigned cycle_count   = 0;

  midi_note_parser_remapper i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_remap_mode      (cfg_remap_mode),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_byte            (out_byte),
    .out_last_of_message (out_last_of_message)
  );

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // remap on the low 7 bits; pass (and the unused code) keeps all 8 bits
  function automatic logic [7:0] remapped_note(input logic [7:0] note,
                                               input logic [1:0] mode);
    logic [7:0] idx;
    idx = note & NOTE_MASK;
    if (mode == MODE_FLIP) begin
      return (idx < 8'd3) ? 8'd0 : 8'(130 - idx);
    end
    if (mode == MODE_MIRROR) begin
      if (idx <= 8'd62) return idx;
      if (idx <= 8'd123) return 8'(124 - idx);
      return 8'd0;
    end
    return note;
  endfunction

  // advance the shadow parser by one byte, queueing the bytes a message emits
  function automatic void parse_midi_byte(input logic [7:0] b);
    case (parse_state)
      PH_NOTE: begin
        // only note-off / note-on carry on; any byte is taken as the note
        if (held_status >= NOTE_OFF && held_status < NOTE_ON_END) begin
          held_note   = b;
          parse_state = PH_VEL;
        end else begin
          parse_state = PH_IDLE;
        end
      end
      PH_VEL: begin
        // the mode in force now is the one applied to the note
        parse_state = PH_IDLE;
        expected_tx.push_back('{held_status, 1'b0});
        expected_tx.push_back('{remapped_note(held_note, remap_setting), 1'b0});
        expected_tx.push_back('{b, 1'b1});
        messages_seen++;
      end
      default: begin
        // idle: keep channel status bytes, drop data and system bytes
        if (b >= STATUS_LOW && b < STATUS_END) begin
          held_status = b;
          parse_state = PH_NOTE;
        end else begin
          parse_state = PH_IDLE;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_output(input logic [7:0] data, input logic last);
    midi_tx_t want;
    if (expected_tx.size() == 0) begin
      report_mismatch($sformatf("output byte %02h with nothing expected", data));
    end else begin
      want = expected_tx.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("output %0d: byte %02h, expected %02h",
                                  results_seen, data, want.data));
      if (last !== want.last)
        report_mismatch($sformatf("output %0d: last flag %b, expected %b",
                                  results_seen, last, want.last));
    end
    results_seen++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: one byte per transaction from the pending queue
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_midi_byte(in_byte);
        bytes_taken++;
      end else if (in_valid) begin
        input_stalls++;
      end
      // the slot is free once nothing is offered or the offer has just gone
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          in_byte  <= pending_bytes.pop_front();
          tx_wait  = sender_idles ? $urandom_range(0, 4) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: takes output transactions and paces out_ready
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_output(out_byte, out_last_of_message);
        rx_wait = receiver_idles ? $urandom_range(0, 4) : 0;
      end
      if (receiver_hold) begin
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off, counted here so the sender keeps going meanwhile
  initial begin
    wait (hold_go);
    @(posedge clk);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs outstanding",
               cycle_count, expected_tx.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------------

  // register write, only ever issued with the block drained
  task automatic write_remap_mode(input logic [1:0] mode_value);
    @(posedge clk);
    cfg_valid      <= 1'b1;
    cfg_remap_mode <= mode_value;
    do @(posedge clk); while (!cfg_ready);
    remap_setting = mode_value;
    cfg_valid     <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every byte to go in and every expected byte to come out
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_tx.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly arbitrary notes, a quarter near the remap break points
  function automatic logic [7:0] pick_note();
    if ($urandom_range(0, 3) == 0)
      return NOTE_BOUNDS[$urandom_range(0, 7)] | {$urandom_range(0, 1) == 0, 7'd0};
    return 8'($urandom_range(0, 255));
  endfunction

  // random traffic: mostly whole note messages, some other channel messages,
  // truncated messages and line noise; noise bytes are not counted
  task automatic queue_note_traffic(input int unsigned target);
    int unsigned counted;
    int unsigned pick;
    counted = 0;
    while (counted < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pending_bytes.push_back(8'($urandom_range(NOTE_OFF, NOTE_ON_END - 1)));
        pending_bytes.push_back(pick_note());
        pending_bytes.push_back(8'($urandom_range(0, 255)));
        counted += 3;
      end else if (pick < 80) begin
        // channel message other than note on/off, cut off after one data byte
        pending_bytes.push_back(8'($urandom_range(NOTE_ON_END, STATUS_END - 1)));
        pending_bytes.push_back(8'($urandom_range(0, 255)));
        counted += 2;
      end else if (pick < 90) begin
        // lone note status; whatever follows is taken as its note
        pending_bytes.push_back(8'($urandom_range(NOTE_OFF, NOTE_ON_END - 1)));
        counted += 1;
      end else begin
        pending_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, under the reset mode (flipped)
    pending_bytes = '{
      8'h00, 8'hFF, 8'h7F,          // data and system bytes ignored while idle
      8'h80, 8'h00, 8'h00,          // note-off, lowest note and velocity
      8'h9F, 8'h02, 8'h7F,          // note-on, last flip-to-zero note
      8'h90, 8'h03, 8'hFF,          // first flipped note, velocity with bit 7
      8'h8A, 8'hFF, 8'h90,          // note byte with bit 7, status as velocity
      8'hA0, 8'h40,                 // aftertouch dropped on its first data byte
      8'hEF, 8'h10,                 // pitch bend, top of the status range
      8'hF0,                        // system exclusive ignored
      8'h95, 8'h7F, 8'h01           // highest note
    };
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    wait_drained();

    write_remap_mode(MODE_MIRROR);
    queue_note_traffic(50);
    wait_drained();

    // gap-free on both sides
    write_remap_mode(MODE_PASS);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    queue_note_traffic(50);
    wait_drained();

    write_remap_mode(MODE_UNUSED);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    queue_note_traffic(20);
    wait_drained();

    // receiver held off while the sender streams: queue fills, input stalls
    write_remap_mode(MODE_FLIP);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    hold_go        = 1'b1;
    queue_note_traffic(40);
    wait_drained();

    write_remap_mode(MODE_MIRROR);
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    queue_note_traffic(30);
    wait_drained();

    if (expected_tx.size() != 0)
      report_mismatch($sformatf("%0d output bytes never arrived", expected_tx.size()));

    $display("run covered %0d input bytes and %0d note messages (%0d output bytes)",
             bytes_taken, messages_seen, results_seen);
    $display("all four remap codes used; input held back on %0d cycles", input_stalls);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", error_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/mnpr_pkg.sv
sv/mnpr_front.sv
sv/mnpr_queue.sv
sv/mnpr_back.sv
sv/midi_note_parser_remapper.sv
dv/tb_midi_note_parser_remapper.sv
